// ===== sv/tcce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared sizes, character codes, command codes and types of the console engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int CELLS        = 4096;
  localparam int ROW_CELLS    = 80;
  localparam int SCREEN_CELLS = 2000;
  localparam int TAB_STOP     = 4;

  localparam int ADDR_W = $clog2(CELLS);
  // positions run past the memory size: origin plus size plus a row
  localparam int POS_W  = ADDR_W + 2;
  localparam int ORG_W  = 12;
  localparam int SIZE_W = 13;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 7;
  localparam int CMD_W  = 2;
  localparam int CELL_W = ATTR_W + CHAR_W;
  localparam int OUT_W  = 12;
  localparam int ROWC_W = $clog2(ROW_CELLS + 1);
  localparam int CNT_W  = (ROWC_W > LEN_W) ? ROWC_W : LEN_W;

  // row number by reciprocal multiply, exact over the position range
  localparam int DIV_SHIFT = POS_W + 8;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] ROW_RECIP =
    RECIP_W'((2 ** DIV_SHIFT + ROW_CELLS - 1) / ROW_CELLS);

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAN  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_ORIGIN    = 2'd0,
    CFG_SIZE      = 2'd1,
    CFG_TEXT_ATTR = 2'd2,
    CFG_HL_ATTR   = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_REM,
    S_TAB_RD,
    S_TAB_WR,
    S_BS_ROW_RD,
    S_BS_ROW_CHK,
    S_BS_ONE_RD,
    S_BS_ONE_CHK,
    S_BS_DEC,
    S_BS_DCHK,
    S_SCR_UP,
    S_SCR_DN,
    S_CLR,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_HL_RD,
    S_HL_WR,
    S_CLN_RD,
    S_CLN_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ORG_W-1:0]  origin;
    logic [SIZE_W-1:0] size;
    logic [ATTR_W-1:0] text_attr;
    logic [ATTR_W-1:0] highlight_attr;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

endpackage

// ===== sv/tcce_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tcce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ctrl
// Command sequencer: read-modify-write passes over the cell memory, cursor
// and view registers, result register.
// ----------------------------------------------------------------------------
module tcce_ctrl
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [CHAR_W-1:0] in_char,
  input  logic [LEN_W-1:0]  in_len,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_cursor,
  output logic [OUT_W-1:0]  out_view,
  output mem_wr_t           mem_wr,
  output logic [ADDR_W-1:0] raddr_a,
  output logic [ADDR_W-1:0] raddr_b,
  input  logic [CELL_W-1:0] rdata_a,
  input  logic [CELL_W-1:0] rdata_b
);

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    cursor_r, cursor_nxt;
  logic [POS_W-1:0]    view_r, view_nxt;
  logic [POS_W-1:0]    p_r, p_nxt;
  logic [POS_W-1:0]    pat_r, pat_nxt;
  logic [POS_W-1:0]    stop_r, stop_nxt;
  logic [POS_W-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [ADDR_W-1:0]   init_r, init_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [CHAR_W-1:0]   ch_r, ch_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_cur_r, out_cur_nxt;
  logic [OUT_W-1:0]    out_view_r, out_view_nxt;

  logic [POS_W-1:0]         org, endp, rel, rem, tab_stop, scan_pos, bs_pos;
  logic [POS_W-1:0]         screen_end;
  logic [POS_W+RECIP_W-1:0] prod;
  logic [CNT_W-1:0]         last_i;
  logic [CHAR_W-1:0]        rd_char;
  logic [ATTR_W-1:0]        rd_attr;

  assign org        = POS_W'(cfg.origin);
  assign endp       = org + POS_W'(cfg.size);
  assign rel        = (cursor_r >= org) ? cursor_r - org : '0;
  assign prod       = POS_W'(rel) * ROW_RECIP;
  assign rem        = rel - POS_W'(q_r * POS_W'(ROW_CELLS));
  assign tab_stop   = (cursor_r & ~POS_W'(TAB_STOP - 1)) + POS_W'(TAB_STOP);
  assign last_i     = CNT_W'(len_r) - CNT_W'(1);
  assign scan_pos   = p_r + POS_W'(i_r);
  assign bs_pos     = cursor_r - POS_W'(1);
  assign screen_end = view_r + POS_W'(SCREEN_CELLS);
  assign rd_char    = rdata_a[CHAR_W-1:0];
  assign rd_attr    = rdata_a[CELL_W-1:CHAR_W];

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_cursor = out_cur_r;
  assign out_view   = out_view_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      out_valid_r <= 1'b0;
      cursor_r    <= '0;
      view_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      cursor_r    <= cursor_nxt;
      view_r      <= view_nxt;
    end
    p_r        <= p_nxt;
    pat_r      <= pat_nxt;
    stop_r     <= stop_nxt;
    q_r        <= q_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    cmd_r      <= cmd_nxt;
    ch_r       <= ch_nxt;
    len_r      <= len_nxt;
    out_cur_r  <= out_cur_nxt;
    out_view_r <= out_view_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    view_nxt      = view_r;
    p_nxt         = p_r;
    pat_nxt       = pat_r;
    stop_nxt      = stop_r;
    q_nxt         = q_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    init_nxt      = init_r;
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_cur_nxt   = out_cur_r;
    out_view_nxt  = out_view_r;
    mem_wr        = '0;
    raddr_a       = '0;
    raddr_b       = '0;

    unique case (state_r)
      S_INIT: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = init_r;
        init_nxt    = init_r + ADDR_W'(1);
        if (init_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_cmd);
          ch_nxt    = in_char;
          len_nxt   = in_len;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        p_nxt = org;
        i_nxt = '0;
        unique case (cmd_r)
          CMD_PUT: begin
            if (ch_r == CH_NEWLINE || ch_r == CH_BACKSPACE) begin
              state_nxt = S_DIV;
            end else if (ch_r == CH_TAB) begin
              state_nxt = S_SCR_UP;
              if (cursor_r + POS_W'(1) < endp) begin
                stop_nxt  = (tab_stop > endp - POS_W'(1)) ? endp - POS_W'(1) : tab_stop;
                state_nxt = S_TAB_RD;
              end
            end else begin
              if (cursor_r + POS_W'(1) < endp) begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = cursor_r[ADDR_W-1:0];
                mem_wr.data = {cfg.text_attr, ch_r};
                cursor_nxt  = cursor_r + POS_W'(1);
              end
              state_nxt = S_SCR_UP;
            end
          end
          CMD_CLEAR: state_nxt = S_CLR;
          CMD_SEARCH: begin
            if (len_r < LEN_W'(2) || cursor_r + POS_W'(1) < POS_W'(len_r)) begin
              state_nxt = S_DONE;
            end else begin
              pat_nxt   = cursor_r + POS_W'(1) - POS_W'(len_r);
              state_nxt = S_SRCH_RD;
            end
          end
          CMD_CLEAN: state_nxt = S_CLN_RD;
          default: state_nxt = S_DONE;
        endcase
      end

      S_DIV: begin
        q_nxt     = POS_W'(prod >> DIV_SHIFT);
        state_nxt = S_REM;
      end

      S_REM: begin
        state_nxt = S_SCR_UP;
        if (ch_r == CH_NEWLINE) begin
          if (cursor_r + POS_W'(ROW_CELLS) < endp) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = cursor_r[ADDR_W-1:0];
            mem_wr.data = {ATTR_W'(0), CH_NEWLINE};
            cursor_nxt  = org + POS_W'((q_r + POS_W'(1)) * POS_W'(ROW_CELLS));
          end
        end else if (cursor_r > org) begin
          if (rem == '0) begin
            p_nxt     = cursor_r - POS_W'(ROW_CELLS);
            i_nxt     = '0;
            state_nxt = S_BS_ROW_RD;
          end else begin
            state_nxt = S_BS_ONE_RD;
          end
        end
      end

      S_TAB_RD: begin
        raddr_a   = cursor_r[ADDR_W-1:0];
        state_nxt = S_TAB_WR;
      end

      S_TAB_WR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = cursor_r[ADDR_W-1:0];
        mem_wr.data = {rd_attr, CH_NUL};
        cursor_nxt  = cursor_r + POS_W'(1);
        state_nxt   = (cursor_r + POS_W'(1) < stop_r) ? S_TAB_RD : S_SCR_UP;
      end

      // backspace at row start: look for the newline in the row above
      S_BS_ROW_RD: begin
        if (i_r == CNT_W'(ROW_CELLS)) begin
          state_nxt = S_SCR_UP;
        end else begin
          raddr_a   = scan_pos[ADDR_W-1:0];
          state_nxt = S_BS_ROW_CHK;
        end
      end

      S_BS_ROW_CHK: begin
        if (rd_char == CH_NEWLINE) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = scan_pos[ADDR_W-1:0];
          mem_wr.data = {cfg.text_attr, CH_SPACE};
          cursor_nxt  = scan_pos;
          state_nxt   = S_SCR_UP;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_BS_ROW_RD;
        end
      end

      S_BS_ONE_RD: begin
        raddr_a   = bs_pos[ADDR_W-1:0];
        state_nxt = S_BS_ONE_CHK;
      end

      S_BS_ONE_CHK: begin
        if (rd_char != CH_NUL) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = bs_pos[ADDR_W-1:0];
          mem_wr.data = {cfg.text_attr, CH_SPACE};
          cursor_nxt  = bs_pos;
          state_nxt   = S_SCR_UP;
        end else begin
          k_nxt     = '0;
          state_nxt = S_BS_DEC;
        end
      end

      // step back over a zero-filled tab run
      S_BS_DEC: begin
        cursor_nxt = bs_pos;
        if (bs_pos <= org || k_r == 2'(TAB_STOP - 1)) begin
          state_nxt = S_SCR_UP;
        end else begin
          raddr_a   = ADDR_W'(bs_pos - POS_W'(1));
          state_nxt = S_BS_DCHK;
        end
      end

      S_BS_DCHK: begin
        if (rd_char != CH_NUL) begin
          state_nxt = S_SCR_UP;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_BS_DEC;
        end
      end

      S_SCR_UP: begin
        if (cursor_r < view_r && view_r > org) begin
          view_nxt = (view_r - org >= POS_W'(ROW_CELLS)) ? view_r - POS_W'(ROW_CELLS) : org;
        end else begin
          state_nxt = S_SCR_DN;
        end
      end

      S_SCR_DN: begin
        if (cursor_r >= screen_end && screen_end < endp) begin
          view_nxt = view_r + POS_W'(ROW_CELLS);
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_CLR: begin
        if (p_r < cursor_r) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = p_r[ADDR_W-1:0];
          mem_wr.data = {cfg.text_attr, CH_SPACE};
          p_nxt       = p_r + POS_W'(1);
        end else begin
          cursor_nxt = org;
          view_nxt   = org;
          state_nxt  = S_DONE;
        end
      end

      S_SRCH_RD: begin
        if (p_r >= pat_r) begin
          state_nxt = S_DONE;
        end else begin
          raddr_a   = scan_pos[ADDR_W-1:0];
          raddr_b   = ADDR_W'(pat_r + POS_W'(i_r));
          state_nxt = S_SRCH_CHK;
        end
      end

      S_SRCH_CHK: begin
        if (rd_char != rdata_b[CHAR_W-1:0]) begin
          p_nxt     = p_r + POS_W'(1);
          i_nxt     = '0;
          state_nxt = S_SRCH_RD;
        end else if (i_r + CNT_W'(1) == last_i) begin
          i_nxt     = '0;
          state_nxt = S_HL_RD;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end

      S_HL_RD: begin
        raddr_a   = scan_pos[ADDR_W-1:0];
        state_nxt = S_HL_WR;
      end

      S_HL_WR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = scan_pos[ADDR_W-1:0];
        mem_wr.data = {cfg.highlight_attr, rd_char};
        if (i_r + CNT_W'(1) == last_i) begin
          i_nxt     = '0;
          p_nxt     = p_r + POS_W'(1);
          state_nxt = S_SRCH_RD;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_HL_RD;
        end
      end

      S_CLN_RD: begin
        if (p_r < cursor_r) begin
          raddr_a   = p_r[ADDR_W-1:0];
          state_nxt = S_CLN_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_CLN_WR: begin
        if (rd_attr == cfg.highlight_attr) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = p_r[ADDR_W-1:0];
          mem_wr.data = {cfg.text_attr, rd_char};
        end
        p_nxt     = p_r + POS_W'(1);
        state_nxt = S_CLN_RD;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cur_nxt   = cursor_r[OUT_W-1:0];
          out_view_nxt  = view_r[OUT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== sv/text_console_cell_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_engine
// Console region engine: character-cell memory, cursor and view start.
// ----------------------------------------------------------------------------
// work: newline and backspace first split the cursor into row and column;
//   tab fills cells up to the next stop, backspace scans back cell by cell,
//   clear and clean pass over the cells from the origin up to the cursor,
//   search compares and highlights cell by cell; a put then scrolls the view row by row
// throughput: one request at a time; the next is taken while the result waits
// reset: synchronous active-low; afterwards a clearing pass over all 4096 cells
//   zeroes the cell memory before the first request is taken
module text_console_cell_engine
  import tcce_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // char_code [7:0], pattern_len [14:8]
  input  logic [CMD_W-1:0]    in_tuser,   // cmd [1:0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // cursor_pos [11:0], view_start [23:12]
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [SIZE_W-1:0]   cfg_data
);

  cfg_t              cfg_r;
  mem_wr_t           mem_wr;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [CELL_W-1:0] rdata_a, rdata_b;
  logic [OUT_W-1:0]  out_cursor, out_view;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin         <= '0;
      cfg_r.size           <= SIZE_W'(4000);
      cfg_r.text_attr      <= ATTR_W'(7);
      cfg_r.highlight_attr <= ATTR_W'(12);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN:    cfg_r.origin         <= cfg_data[ORG_W-1:0];
        CFG_SIZE:      cfg_r.size           <= cfg_data;
        CFG_TEXT_ATTR: cfg_r.text_attr      <= cfg_data[ATTR_W-1:0];
        CFG_HL_ATTR:   cfg_r.highlight_attr <= cfg_data[ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  tcce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_char    (in_tdata[7:0]),
    .in_len     (in_tdata[14:8]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_cursor (out_cursor),
    .out_view   (out_view),
    .mem_wr     (mem_wr),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b)
  );

  // two copies written together give a second read port for search
  tcce_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram_a (
    .clk   (clk),
    .we    (mem_wr.en),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  tcce_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram_b (
    .clk   (clk),
    .we    (mem_wr.en),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign out_tdata = {out_view, out_cursor};

endmodule

// ===== sv/tcce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the console engine, bound to the top level.
// ----------------------------------------------------------------------------
module tcce_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [23:0]       out_tdata,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  // memory clearing pass holds off requests right after reset
  a_init_hold: assert property (@(posedge clk) $rose(rst_n) |-> !in_tready)
    else $error("request taken during clearing pass");

  // a taken request keeps the engine busy: no request is taken right after it
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##1 !in_tready ##1 !in_tready)
    else $error("engine took a request while busy");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind text_console_cell_engine tcce_checker u_tcce_checker (.*);
